[rtl/lrpt_pkg.sv]
// ----------------------------------------------------------------------------
// lrpt_pkg
// Shared types and codes for the loop/repeat playback timer.
// ----------------------------------------------------------------------------
package lrpt_pkg;

  localparam int TIME_W = 32;
  localparam int NOW_W  = 31;
  localparam int VAL_W  = 16;
  localparam int KIND_W = 3;
  localparam int IDX_W  = 3;

  // event kinds
  localparam logic [KIND_W-1:0] KIND_TICK   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PLAY   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_STOP   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_PAUSE  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RESUME = 3'd4;
  localparam logic [KIND_W-1:0] KIND_FINISH = 3'd5;

  // register indexes
  localparam logic [IDX_W-1:0] REG_DURATION   = 3'd0;
  localparam logic [IDX_W-1:0] REG_LOOP_TOTAL = 3'd1;
  localparam logic [IDX_W-1:0] REG_MODE       = 3'd2;
  localparam logic [IDX_W-1:0] REG_START_DLY  = 3'd3;
  localparam logic [IDX_W-1:0] REG_REPEAT_MIN = 3'd4;
  localparam logic [IDX_W-1:0] REG_REPEAT_MAX = 3'd5;
  localparam logic [IDX_W-1:0] REG_SPEED      = 3'd6;

  // mode bits
  localparam int MODE_FOREVER = 0;
  localparam int MODE_REPEAT  = 1;
  localparam int MODE_AT_REP  = 2;

  typedef enum logic [2:0] {
    ST_IDLE        = 3'd0,
    ST_WAIT_START  = 3'd1,
    ST_PLAYING     = 3'd2,
    ST_WAIT_REPEAT = 3'd3,
    ST_STALLED     = 3'd4,
    ST_PAUSED      = 3'd5
  } state_e_t;

  typedef struct packed {
    logic [VAL_W-1:0] duration;
    logic [VAL_W-1:0] loop_total;
    logic [2:0]       mode;
    logic [VAL_W-1:0] start_delay;
    logic [VAL_W-1:0] repeat_min;
    logic [VAL_W-1:0] repeat_max;
    logic [VAL_W-1:0] speed;
  } cfg_t;

  typedef struct packed {
    state_e_t          run_state;
    state_e_t          saved_state;
    logic [TIME_W-1:0] play_start_time;
    logic [VAL_W-1:0]  play_offset;
    logic [TIME_W-1:0] resume_deadline;
    logic [TIME_W-1:0] pause_time;
    logic [VAL_W-1:0]  loops_done;
    logic [VAL_W-1:0]  current_position;
    logic [1:0]        working_mode;
    logic [VAL_W-1:0]  working_loop_total;
  } state_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [NOW_W-1:0]  now_ms;
    logic [VAL_W-1:0]  start_offset_ms;
    logic [VAL_W-1:0]  random_fraction;
  } req_t;

  typedef struct packed {
    logic [VAL_W-1:0] position_ms;
    logic             position_fresh;
    logic             started;
    logic             stopped;
    logic             ticked;
    logic [2:0]       player_state;
  } result_t;

endpackage

[rtl/lrpt_step.sv]
// ----------------------------------------------------------------------------
// lrpt_step
// Next-state and result logic for one timer event.
// ----------------------------------------------------------------------------
module lrpt_step
  import lrpt_pkg::*;
(
  input  cfg_t    cfg,
  input  state_t  cur,
  input  req_t    req,
  output state_t  nxt,
  output result_t res
);

  logic [TIME_W-1:0]   now32;
  logic [TIME_W-1:0]   diff;
  logic [TIME_W-1:0]   span;
  logic [47:0]         prod;
  logic [39:0]         raw;
  logic                loop_end;
  logic [VAL_W-1:0]    period;
  logic [31:0]         jitter;
  logic [TIME_W-1:0]   rep_deadline;
  logic [VAL_W-1:0]    clamp_offs_in;
  logic [VAL_W-1:0]    clamp_offs_st;
  logic [VAL_W-1:0]    loops_inc;

  always_comb begin
    now32 = {1'b0, req.now_ms};
    diff  = now32 - cur.play_start_time;
    if (diff[TIME_W-1]) begin
      diff = '0;
    end
    // diff < 2^31 here, so the sum fits 32 bits
    span     = diff + {16'd0, cur.play_offset};
    prod     = span * cfg.speed;
    raw      = prod[47:8];
    loop_end = raw >= {24'd0, cfg.duration};

    period = (cfg.repeat_max > cfg.repeat_min) ? (cfg.repeat_max - cfg.repeat_min) : '0;
    jitter = period * req.random_fraction;
    rep_deadline = now32 + {16'd0, cfg.repeat_min} + {16'd0, jitter[31:16]};

    clamp_offs_in = (req.start_offset_ms > cfg.duration) ? cfg.duration : req.start_offset_ms;
    clamp_offs_st = (cur.play_offset > cfg.duration) ? cfg.duration : cur.play_offset;
    loops_inc     = (cur.loops_done != 16'hFFFF) ? (cur.loops_done + 16'd1) : cur.loops_done;
  end

  // next state
  always_comb begin
    nxt = cur;
    case (req.kind)
      KIND_TICK: begin
        if (cur.run_state != ST_IDLE) begin
          if (cur.run_state == ST_PLAYING) begin
            if (loop_end) begin
              nxt.current_position = cfg.duration;
              if (cur.working_mode[MODE_FOREVER]) begin
                nxt.play_start_time  = now32;
                nxt.play_offset      = '0;
                nxt.current_position = '0;
              end else begin
                nxt.loops_done = loops_inc;
                if (loops_inc < cur.working_loop_total) begin
                  nxt.play_start_time  = now32;
                  nxt.play_offset      = '0;
                  nxt.current_position = '0;
                end else if (cur.working_mode[MODE_REPEAT]) begin
                  nxt.resume_deadline = rep_deadline;
                  nxt.run_state       = ST_WAIT_REPEAT;
                  nxt.play_offset     = '0;
                end else begin
                  nxt.run_state = ST_STALLED;
                end
              end
            end else begin
              nxt.current_position = raw[VAL_W-1:0];
            end
          end else if ((cur.run_state == ST_WAIT_REPEAT) ||
                       (cur.run_state == ST_WAIT_START)) begin
            if (now32 >= cur.resume_deadline) begin
              nxt.loops_done       = '0;
              nxt.play_start_time  = now32;
              nxt.current_position = clamp_offs_st;
              nxt.run_state        = ST_PLAYING;
            end
          end
        end
      end
      KIND_PLAY: begin
        nxt.working_mode       = cfg.mode[1:0];
        nxt.working_loop_total = cfg.loop_total;
        nxt.play_offset        = req.start_offset_ms;
        nxt.current_position   = clamp_offs_in;
        nxt.loops_done         = '0;
        if (!cfg.mode[MODE_FOREVER] && cfg.mode[MODE_REPEAT] && cfg.mode[MODE_AT_REP]) begin
          nxt.resume_deadline = rep_deadline;
          nxt.run_state       = ST_WAIT_REPEAT;
        end else if (cfg.start_delay != '0) begin
          nxt.resume_deadline = now32 + {16'd0, cfg.start_delay};
          nxt.run_state       = ST_WAIT_START;
        end else begin
          nxt.play_start_time = now32;
          nxt.run_state       = ST_PLAYING;
        end
      end
      KIND_STOP: begin
        if (cur.run_state != ST_IDLE) begin
          nxt.run_state = ST_IDLE;
        end
      end
      KIND_PAUSE: begin
        if ((cur.run_state != ST_IDLE) && (cur.run_state != ST_PAUSED)) begin
          nxt.saved_state = cur.run_state;
          nxt.pause_time  = now32;
          nxt.run_state   = ST_PAUSED;
        end
      end
      KIND_RESUME: begin
        if (cur.run_state == ST_PAUSED) begin
          nxt.run_state       = cur.saved_state;
          nxt.play_start_time = cur.play_start_time + (now32 - cur.pause_time);
        end
      end
      KIND_FINISH: begin
        nxt.working_mode       = '0;
        nxt.loops_done         = '0;
        nxt.working_loop_total = 16'd1;
      end
      default: begin
      end
    endcase
  end

  // result flags and position
  always_comb begin
    res = '0;
    case (req.kind)
      KIND_TICK: begin
        if (cur.run_state != ST_IDLE) begin
          res.ticked = 1'b1;
        end
        if (cur.run_state == ST_PLAYING) begin
          res.position_fresh = 1'b1;
        end else if (((cur.run_state == ST_WAIT_REPEAT) ||
                      (cur.run_state == ST_WAIT_START)) &&
                     (now32 >= cur.resume_deadline)) begin
          res.position_fresh = 1'b1;
        end
      end
      KIND_PLAY: begin
        res.started        = 1'b1;
        res.position_fresh = (nxt.run_state == ST_PLAYING);
      end
      KIND_STOP: begin
        res.stopped = (cur.run_state != ST_IDLE);
      end
      default: begin
      end
    endcase

    // a loop end reports the full duration even when the position restarts
    if ((req.kind == KIND_TICK) && (cur.run_state == ST_PLAYING) && loop_end) begin
      res.position_ms = cfg.duration;
    end else begin
      res.position_ms = nxt.current_position;
    end
    res.player_state = nxt.run_state;
  end

endmodule

[rtl/loop_repeat_playback_timer_top.sv]
// ----------------------------------------------------------------------------
// loop_repeat_playback_timer_top
// Playback timer for looped sequences with repeat delay and pause/resume.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready): one event request per accept, with
//    its kind, the current ms time, a start offset and a random fraction.
//  - Output channel (out_valid/out_ready): exactly one result per event,
//    in order: position, fresh/started/stopped/ticked flags, player state.
//  - Config channel (cfg_valid/cfg_ready): cfg_index selects the register,
//    cfg_data carries the value. Always ready. Write only while idle.
//  - Result path: the input register, then the step logic feeds the result
//    register; out_valid rises once the result is registered.
//  - Throughput: one event per cycle while the receiver takes results; the
//    step logic, with a 32x16 position multiplier and a 16x16 deadline
//    multiplier, sits between the input and result registers.
//  - Receiver stall: the result register holds; the input register still
//    takes one more request, then in_ready drops until the result is taken.
//  - Reset (rst_n low, synchronous): player idle, all timer state zero,
//    registers back to their defaults (duration 1000, loop total 1,
//    speed 1.0, others zero), both channels empty.
// ----------------------------------------------------------------------------
module loop_repeat_playback_timer_top
  import lrpt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // events
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [KIND_W-1:0] in_kind,
  input  logic [NOW_W-1:0]  in_now_ms,
  input  logic [VAL_W-1:0]  in_start_offset_ms,
  input  logic [VAL_W-1:0]  in_random_fraction,
  // results
  output logic              out_valid,
  input  logic              out_ready,
  output logic [VAL_W-1:0]  out_position_ms,
  output logic              out_position_fresh,
  output logic              out_started,
  output logic              out_stopped,
  output logic              out_ticked,
  output logic [2:0]        out_player_state,
  // configuration writes
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [VAL_W-1:0]  cfg_data
);

  cfg_t    cfg_r;
  state_t  state_r;
  state_t  state_nxt;
  req_t    req_r;
  logic    req_valid_r;
  result_t res_nxt;
  result_t res_r;
  logic    out_valid_r;
  logic    advance;

  // Step fires when a request is held and the result slot is free or
  // being emptied this cycle.
  assign advance   = req_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !req_valid_r || advance;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.duration    <= 16'd1000;
      cfg_r.loop_total  <= 16'd1;
      cfg_r.mode        <= '0;
      cfg_r.start_delay <= '0;
      cfg_r.repeat_min  <= '0;
      cfg_r.repeat_max  <= '0;
      cfg_r.speed       <= 16'd256;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DURATION:   cfg_r.duration    <= cfg_data;
        REG_LOOP_TOTAL: cfg_r.loop_total  <= cfg_data;
        REG_MODE:       cfg_r.mode        <= cfg_data[2:0];
        REG_START_DLY:  cfg_r.start_delay <= cfg_data;
        REG_REPEAT_MIN: cfg_r.repeat_min  <= cfg_data;
        REG_REPEAT_MAX: cfg_r.repeat_max  <= cfg_data;
        REG_SPEED:      cfg_r.speed       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_ready) begin
      req_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r.kind            <= in_kind;
      req_r.now_ms          <= in_now_ms;
      req_r.start_offset_ms <= in_start_offset_ms;
      req_r.random_fraction <= in_random_fraction;
    end
  end

  lrpt_step u_step (
    .cfg (cfg_r),
    .cur (state_r),
    .req (req_r),
    .nxt (state_nxt),
    .res (res_nxt)
  );

  // timer state, updated once per processed event
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_position_ms    = res_r.position_ms;
  assign out_position_fresh = res_r.position_fresh;
  assign out_started        = res_r.started;
  assign out_stopped        = res_r.stopped;
  assign out_ticked         = res_r.ticked;
  assign out_player_state   = res_r.player_state;

endmodule
